// File: sv/lia_pkg.sv
// ----------------------------------------------------------------------------
// lia_pkg
// Shared types and constants of the line input assembler.
// ----------------------------------------------------------------------------
package lia_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } lia_func_t;

  // Characters
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_DEL = 8'd127;
  localparam logic [7:0] CHAR_N   = 8'h6E;
  localparam logic [7:0] CHAR_R   = 8'h72;

  // Line store geometry
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = 5;
  localparam int LEN_W       = 5;
  localparam logic [LEN_W-1:0] LEN_CAP = 5'd31;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One classified request with its resolved result bytes
  typedef struct packed {
    logic             pair;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic             ready;
    logic [LEN_W-1:0] len;
  } lia_cmd_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic              nonempty;
    logic [QCNT_W-1:0] count;
  } lia_qstat_t;

endpackage

// File: sv/lia_ram.sv
// ----------------------------------------------------------------------------
// lia_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lia_front.sv
// ----------------------------------------------------------------------------
// lia_front
// Accepts requests, keeps the line state, writes and reads the line store and
// hands one classified command per result-producing request to the queue.
// ----------------------------------------------------------------------------
module lia_front import lia_pkg::*; #(
  parameter int MAX_LEN = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        func,
  input  logic [7:0]        rx_byte,
  input  logic [ADDR_W-1:0] read_index,
  input  lia_qstat_t        qstat,
  output logic              q_push,
  output lia_cmd_t          q_data
);

  localparam logic [LEN_W-1:0] ROOM =
    (MAX_LEN > 31) ? LEN_CAP : LEN_W'(MAX_LEN);

  logic [LEN_W-1:0] fill_count, fill_count_next;
  logic [LEN_W-1:0] stored_length, stored_length_next;
  logic             pending_flag, pending_flag_next;

  logic             s1_valid, s1_valid_next;
  logic             s1_is_read, s1_is_read_next;
  lia_cmd_t         s1_cmd, s1_cmd_next;

  logic             accept;
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic [QCNT_W:0]  occupancy;

  // Hold back new requests once queued plus in-flight commands fill the queue
  assign occupancy = {1'b0, qstat.count} + {{QCNT_W{1'b0}}, s1_valid};
  assign full      = (occupancy >= (QCNT_W+1)'(QDEPTH));
  assign accept    = push && !full;

  // Classify the request and work out the next line state
  always_comb begin
    fill_count_next    = fill_count;
    stored_length_next = stored_length;
    pending_flag_next  = pending_flag;
    s1_valid_next      = 1'b0;
    s1_is_read_next    = 1'b0;
    s1_cmd_next        = '0;
    ram_we             = 1'b0;
    ram_wdata          = rx_byte;
    if (accept) begin
      case (lia_func_t'(func))
        FUNC_BYTE: begin
          if (pending_flag) begin
            s1_valid_next     = 1'b1;
            s1_cmd_next.pair  = 1'b1;
            s1_cmd_next.byte0 = CHAR_N;
            s1_cmd_next.byte1 = CHAR_R;
          end else begin
            case (rx_byte) inside
              CHAR_LF, CHAR_CR: begin
                ram_we             = 1'b1;
                ram_wdata          = 8'd0;
                stored_length_next = fill_count;
                fill_count_next    = '0;
                pending_flag_next  = 1'b1;
                s1_valid_next      = 1'b1;
                s1_cmd_next.pair   = 1'b1;
                s1_cmd_next.byte0  = CHAR_LF;
                s1_cmd_next.byte1  = CHAR_CR;
              end
              CHAR_DEL: begin
                if (fill_count != '0) begin
                  fill_count_next = fill_count - LEN_W'(1);
                end
              end
              default: begin
                if (fill_count < ROOM) begin
                  ram_we            = 1'b1;
                  fill_count_next   = fill_count + LEN_W'(1);
                  s1_valid_next     = 1'b1;
                  s1_cmd_next.byte0 = rx_byte;
                end
              end
            endcase
          end
        end
        FUNC_RELEASE: begin
          pending_flag_next = 1'b0;
          s1_valid_next     = 1'b1;
        end
        FUNC_READ: begin
          s1_valid_next   = 1'b1;
          s1_is_read_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
    s1_cmd_next.ready = pending_flag_next;
    s1_cmd_next.len   = stored_length_next;
  end

  // Line state and the command stage that waits on the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      stored_length <= '0;
      pending_flag  <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      fill_count    <= fill_count_next;
      stored_length <= stored_length_next;
      pending_flag  <= pending_flag_next;
      s1_valid      <= s1_valid_next;
    end
    s1_is_read <= s1_is_read_next;
    s1_cmd     <= s1_cmd_next;
  end

  lia_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_count),
    .wdata(ram_wdata),
    .raddr(read_index),
    .rdata(ram_rdata)
  );

  // Resolve the stored byte for a read and pass the command on
  always_comb begin
    q_push = s1_valid;
    q_data = s1_cmd;
    if (s1_is_read) begin
      q_data.byte0 = ram_rdata;
    end
  end

endmodule

// File: sv/lia_queue.sv
// ----------------------------------------------------------------------------
// lia_queue
// Short command queue that decouples the front from the result sequencer.
// ----------------------------------------------------------------------------
module lia_queue import lia_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_push,
  input  lia_cmd_t   q_data,
  input  logic       q_pop,
  output lia_cmd_t   q_head,
  output lia_qstat_t qstat
);

  lia_cmd_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign do_pop         = q_pop && (count != '0);
  assign q_head         = entries[rd_ptr];
  assign qstat.nonempty = (count != '0);
  assign qstat.count    = count;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (q_push) begin
      entries[wr_ptr] <= q_data;
    end
  end

  // Advance the pointers and the count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({q_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/lia_back.sv
// ----------------------------------------------------------------------------
// lia_back
// Result sequencer: turns each queued command into one or two results and
// presents them through an output register.
// ----------------------------------------------------------------------------
module lia_back import lia_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lia_cmd_t         q_head,
  input  lia_qstat_t       qstat,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             line_ready,
  output logic [LEN_W-1:0] line_length
);

  logic             out_valid, out_valid_next;
  logic             sec_pending, sec_pending_next;
  logic [7:0]       sec_byte;
  logic             sec_ready;
  logic [LEN_W-1:0] sec_len;
  logic             load;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign q_pop = load && !sec_pending && qstat.nonempty;

  // Pick what the output register takes next
  always_comb begin
    out_valid_next   = out_valid;
    sec_pending_next = sec_pending;
    if (load) begin
      if (sec_pending) begin
        out_valid_next   = 1'b1;
        sec_pending_next = 1'b0;
      end else if (qstat.nonempty) begin
        out_valid_next   = 1'b1;
        sec_pending_next = q_head.pair;
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      sec_pending <= 1'b0;
    end else begin
      out_valid   <= out_valid_next;
      sec_pending <= sec_pending_next;
    end
  end

  // Output and second-result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_pending) begin
        out_byte    <= sec_byte;
        out_last    <= 1'b1;
        line_ready  <= sec_ready;
        line_length <= sec_len;
      end else if (qstat.nonempty) begin
        out_byte    <= q_head.byte0;
        out_last    <= !q_head.pair;
        line_ready  <= q_head.ready;
        line_length <= q_head.len;
        sec_byte    <= q_head.byte1;
        sec_ready   <= q_head.ready;
        sec_len     <= q_head.len;
      end
    end
  end

endmodule

// File: sv/line_input_assembler_unit.sv
// ----------------------------------------------------------------------------
// line_input_assembler_unit
// Serial line editor: collects received bytes into a 32-byte line store,
// echoes them, and answers release and read requests.
// ----------------------------------------------------------------------------
// A request is accepted in any cycle in which full is low, including while
// results wait at the output; each result passes through the read stage,
// the command queue and the output register. The output register hands out
// one result per cycle while pop is high. A stored byte, a release or a read
// produces one result and an echoed line end or a refused byte ('n','r')
// produces two; deletes, dropped bytes and the unused request code produce
// nothing. A four-entry command queue sits between the request side and the
// result side; full rises once queued commands plus the read stage fill it.
// No clearing pass follows reset: the line store holds unknown data until
// written, and reading such an entry returns an undefined byte.
module line_input_assembler_unit import lia_pkg::*; #(
  parameter int MAX_LEN = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       func,
  input  logic [7:0]       rx_byte,
  input  logic [4:0]       read_index,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             line_ready,
  output logic [LEN_W-1:0] line_length
);

  lia_qstat_t qstat;
  lia_cmd_t   q_data;
  lia_cmd_t   q_head;
  logic       q_push;
  logic       q_pop;

  lia_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .rx_byte   (rx_byte),
    .read_index(read_index),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  lia_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .q_push(q_push),
    .q_data(q_data),
    .q_pop (q_pop),
    .q_head(q_head),
    .qstat (qstat)
  );

  lia_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_head     (q_head),
    .qstat      (qstat),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .line_ready (line_ready),
    .line_length(line_length)
  );

endmodule

// File: sv/lia_checker.sv
// ----------------------------------------------------------------------------
// lia_checker
// Port-level checks of the line input assembler, bound to the top level.
// ----------------------------------------------------------------------------
module lia_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       line_ready,
  input logic [4:0] line_length
);

  // Reset leaves no result and room for requests
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result or full after reset");

  // The second result of a pair follows straight after the first
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_last) |=> !empty)
    else $error("second result of a pair missing");

  // Both results of a pair carry the same line status
  a_pair_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_last) |=>
      (line_ready == $past(line_ready) && line_length == $past(line_length)))
    else $error("line status changed within a pair");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("waiting result changed");

endmodule

bind line_input_assembler_unit lia_checker u_lia_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .out_last   (out_last),
  .line_ready (line_ready),
  .line_length(line_length)
);
